// ===== rtl/core/acp_pkg.sv =====
// Shared types, character codes and helper functions of the ASCII command parser.
`default_nettype none

package acp_pkg;

    localparam int LINE_LIMIT_DEF = 30;
    localparam logic [7:0] OWN_ADDRESS_RST = 8'h01;

    localparam logic [7:0] ADDR_BROADCAST = 8'h00;
    localparam logic [7:0] ADDR_DEFAULT   = 8'hFF;

    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_HELP  = 8'h3f;  // '?'
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    localparam logic [7:0] CMD_SET  = 8'h73;  // 's'
    localparam logic [7:0] CMD_READ = 8'h72;  // 'r'
    localparam logic [7:0] CMD_EXEC = 8'h65;  // 'e'

    localparam logic [7:0] SUB_GOTO   = 8'h67;  // 'g'
    localparam logic [7:0] SUB_GAIN_P = 8'h70;  // 'p'
    localparam logic [7:0] SUB_GAIN_I = 8'h69;  // 'i'
    localparam logic [7:0] SUB_GAIN_D = 8'h64;  // 'd'
    localparam logic [7:0] SUB_PERIOD = 8'h74;  // 't'
    localparam logic [7:0] SUB_ERRSUM = 8'h65;  // 'e'
    localparam logic [7:0] SUB_ADDR   = 8'h61;  // 'a'
    localparam logic [7:0] SUB_SYNC   = 8'h73;  // 's'
    localparam logic [7:0] SUB_DEBUG  = 8'h64;  // 'd'

    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

    typedef enum logic [3:0] {
        EV_HELP      = 4'd0,
        EV_GOTO      = 4'd1,
        EV_GAIN_P    = 4'd2,
        EV_GAIN_I    = 4'd3,
        EV_GAIN_D    = 4'd4,
        EV_PERIOD    = 4'd5,
        EV_ERRSUM    = 4'd6,
        EV_ADDR_REQ  = 4'd7,
        EV_SYNC      = 4'd8,
        EV_DEBUG     = 4'd9
    } evt_code_t;

    typedef enum logic [1:0] {
        PH_BLANK = 2'd0,
        PH_DIGIT = 2'd1,
        PH_DONE  = 2'd2
    } num_phase_t;

    typedef struct packed {
        logic               valid;
        evt_code_t          code;
        logic [7:0]         addr;
        logic signed [31:0] arg;
        logic [7:0]         dbg;
    } evt_t;

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] n;
        n = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            n = c[3:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            n = c[3:0] + 4'd9;
        end
        return n;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/addressed_ascii_command_parser.sv =====
// Top level of the addressed ASCII command parser: ports, address register, event register.
//
//   channel | direction | handshake           | payload
//   rx      | in        | rx_valid / rx_stall   | rx_byte
//   evt     | out       | evt_valid / evt_stall | event_code, line_address,
//           |           |                       | argument_value, debug_selector
//   cfg     | in        | cfg_valid / cfg_ready | cfg_data (own address)
//
// One byte is taken per cycle while rx_stall is low; its event, if any, appears in evt_valid in the cycle after.
// The line state sits in flip-flops and the byte is decoded combinationally.
// rx_stall rises only while an event waits in the output register and evt_stall is high.
// Reset leaves an empty line and own address 0x01; cfg_ready is always high.
`default_nettype none

module addressed_ascii_command_parser #(
    parameter int LINE_LIMIT = acp_pkg::LINE_LIMIT_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               rx_valid,
    output logic                    rx_stall,
    input  wire logic [7:0]         rx_byte,
    output logic                    evt_valid,
    input  wire logic               evt_stall,
    output logic [3:0]              event_code,
    output logic [7:0]              line_address,
    output logic signed [31:0]      argument_value,
    output logic [7:0]              debug_selector,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [7:0]         cfg_data
);
    import acp_pkg::*;

    logic       step;
    evt_t       evt;
    evt_t       evt_reg;
    logic [7:0] own_address_reg;

    assign rx_stall  = evt_reg.valid && evt_stall;
    assign step      = rx_valid && !rx_stall;
    assign cfg_ready = 1'b1;

    acp_line #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_line (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .rx_byte     (rx_byte),
        .own_address (own_address_reg),
        .evt         (evt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg <= OWN_ADDRESS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            own_address_reg <= cfg_data;
        end
    end

    // A waiting event leaves on a transfer; a new one may load in the same cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_reg <= '0;
        end
        else if (step && evt.valid)
        begin
            evt_reg <= evt;
        end
        else if (!evt_stall)
        begin
            evt_reg.valid <= 1'b0;
        end
    end

    assign evt_valid      = evt_reg.valid;
    assign event_code     = evt_reg.code;
    assign line_address   = evt_reg.addr;
    assign argument_value = evt_reg.arg;
    assign debug_selector = evt_reg.dbg;

endmodule

`default_nettype wire

// ===== rtl/core/acp_line.sv =====
// Line assembly state, argument accumulator and event decode of the command parser.
`default_nettype none

module acp_line #(
    parameter int LINE_LIMIT = acp_pkg::LINE_LIMIT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [7:0]  own_address,
    output acp_pkg::evt_t    evt
);
    import acp_pkg::*;

    localparam int POS_W = $clog2(LINE_LIMIT);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(LINE_LIMIT - 1);

    logic [POS_W-1:0] pos_reg;
    logic [7:0]       dest_reg, dest_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [7:0]       sub_reg, sub_next;
    logic [7:0]       first_reg, first_next;
    logic [31:0]      val_reg, val_next;
    logic             neg_reg, neg_next;
    num_phase_t       phase_reg, phase_next;

    logic        help;
    logic        commit;
    logic        addr_ok;
    logic        hit;
    evt_code_t   code;
    logic [35:0] prod;
    logic [31:0] sarg;

    // Times ten as two shifts plus the new digit.
    assign prod = ({4'b0, val_reg} << 3) + ({4'b0, val_reg} << 1) + 36'(rx_byte[3:0]);

    always_comb
    begin
        dest_next  = dest_reg;
        cmd_next   = cmd_reg;
        sub_next   = sub_reg;
        first_next = first_reg;
        val_next   = val_reg;
        neg_next   = neg_reg;
        phase_next = phase_reg;
        if (pos_reg == POS_W'(0))
        begin
            dest_next = {hex_nibble(rx_byte), 4'd0};
        end
        else if (pos_reg == POS_W'(1))
        begin
            dest_next = {dest_reg[7:4], hex_nibble(rx_byte)};
        end
        else if (pos_reg == POS_W'(2))
        begin
            cmd_next = rx_byte;
        end
        else if (pos_reg == POS_W'(3))
        begin
            sub_next = rx_byte;
        end
        else
        begin
            if (pos_reg == POS_W'(4))
            begin
                first_next = rx_byte;
            end
            unique case (phase_reg)
                PH_BLANK:
                begin
                    if (rx_byte == CH_PLUS || rx_byte == CH_MINUS)
                    begin
                        neg_next   = (rx_byte == CH_MINUS);
                        phase_next = PH_DIGIT;
                    end
                    else if (is_digit(rx_byte))
                    begin
                        phase_next = PH_DIGIT;
                        val_next   = (prod > {4'b0, MAG_LIMIT}) ? MAG_LIMIT : prod[31:0];
                    end
                    else if (!is_blank(rx_byte))
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_DIGIT:
                begin
                    if (is_digit(rx_byte))
                    begin
                        val_next = (prod > {4'b0, MAG_LIMIT}) ? MAG_LIMIT : prod[31:0];
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    assign help    = (pos_reg == POS_W'(2)) && (rx_byte == CH_HELP);
    assign commit  = (rx_byte == CH_LF) || (pos_reg >= LAST_POS);
    assign addr_ok = (dest_next == ADDR_BROADCAST) || (dest_next == ADDR_DEFAULT)
                     || (dest_next == own_address);
    assign sarg    = neg_next ? (32'd0 - val_next)
                              : ((val_next > POS_MAX) ? POS_MAX : val_next);

    always_comb
    begin
        hit  = 1'b0;
        code = EV_HELP;
        unique case (cmd_next)
            CMD_SET:
            begin
                hit = 1'b1;
                unique case (sub_next)
                    SUB_GOTO:   code = EV_GOTO;
                    SUB_GAIN_P: code = EV_GAIN_P;
                    SUB_GAIN_I: code = EV_GAIN_I;
                    SUB_GAIN_D: code = EV_GAIN_D;
                    SUB_PERIOD: code = EV_PERIOD;
                    SUB_ERRSUM: code = EV_ERRSUM;
                    default:    hit  = 1'b0;
                endcase
            end
            CMD_READ:
            begin
                hit  = (sub_next == SUB_ADDR) && (dest_next == ADDR_BROADCAST);
                code = EV_ADDR_REQ;
            end
            CMD_EXEC:
            begin
                hit = 1'b1;
                unique case (sub_next)
                    SUB_SYNC:  code = EV_SYNC;
                    SUB_DEBUG: code = EV_DEBUG;
                    default:   hit  = 1'b0;
                endcase
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        evt.valid = 1'b0;
        evt.code  = code;
        evt.addr  = dest_next;
        evt.arg   = '0;
        evt.dbg   = 8'd0;
        if (help)
        begin
            evt.valid = 1'b1;
            evt.code  = EV_HELP;
        end
        else if (commit && addr_ok && hit)
        begin
            evt.valid = 1'b1;
            if (code >= EV_GOTO && code <= EV_ERRSUM)
            begin
                evt.arg = sarg;
            end
            if (code == EV_DEBUG)
            begin
                evt.dbg = first_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            dest_reg  <= 8'd0;
            cmd_reg   <= 8'd0;
            sub_reg   <= 8'd0;
            first_reg <= 8'd0;
            val_reg   <= 32'd0;
            neg_reg   <= 1'b0;
            phase_reg <= PH_BLANK;
        end
        else if (step)
        begin
            if (help || commit)
            begin
                // Every line restarts from a clean state, matched or not.
                pos_reg   <= '0;
                dest_reg  <= 8'd0;
                cmd_reg   <= 8'd0;
                sub_reg   <= 8'd0;
                first_reg <= 8'd0;
                val_reg   <= 32'd0;
                neg_reg   <= 1'b0;
                phase_reg <= PH_BLANK;
            end
            else
            begin
                pos_reg   <= pos_reg + POS_W'(1);
                dest_reg  <= dest_next;
                cmd_reg   <= cmd_next;
                sub_reg   <= sub_next;
                first_reg <= first_next;
                val_reg   <= val_next;
                neg_reg   <= neg_next;
                phase_reg <= phase_next;
            end
        end
    end

endmodule

`default_nettype wire
